@@ src/ffss_pkg.sv @@
// Shared types, tags and constants for the font file section scanner.
`default_nettype none

package ffss_pkg;

    // Width of the byte position counter and section start pointers
    localparam int POSITION_BITS = 32;

    typedef logic [POSITION_BITS-1:0] pos_t;

    // Fixed file signature length and the mask with every section present
    localparam int          SIG_LEN   = 12;
    localparam logic [6:0]  ALL_FOUND = 7'h7F;

    // Section tags as they read big-endian from the stream
    localparam logic [31:0] TAG_DATA = 32'h4441_5441;
    localparam logic [31:0] TAG_PTSZ = 32'h5054_535A;
    localparam logic [31:0] TAG_MAXW = 32'h4D41_5857;
    localparam logic [31:0] TAG_MAXH = 32'h4D41_5848;
    localparam logic [31:0] TAG_ASCE = 32'h4153_4345;
    localparam logic [31:0] TAG_DESC = 32'h4445_5343;
    localparam logic [31:0] TAG_CHIX = 32'h4348_4958;

    // Found mask bits
    localparam int FLAG_CHIX = 0;
    localparam int FLAG_DESC = 1;
    localparam int FLAG_ASCE = 2;
    localparam int FLAG_MAXH = 3;
    localparam int FLAG_MAXW = 4;
    localparam int FLAG_PTSZ = 5;
    localparam int FLAG_DATA = 6;

    // Kind of section whose two value bytes are being captured
    typedef logic [2:0] kind_t;
    localparam kind_t KIND_NONE = 3'd0;
    localparam kind_t KIND_PTSZ = 3'd1;
    localparam kind_t KIND_MAXW = 3'd2;
    localparam kind_t KIND_MAXH = 3'd3;
    localparam kind_t KIND_ASCE = 3'd4;
    localparam kind_t KIND_DESC = 3'd5;
    localparam int    NUM_VALUES = 5;

    // Result status codes
    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_BAD_SIG  = 2'd1;
    localparam status_t STATUS_MISSING  = 2'd2;

    // One input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } byte_beat_t;

    // One result beat
    typedef struct packed {
        status_t     status;
        logic [6:0]  found_mask;
        logic [15:0] point_size;
        logic [15:0] max_width;
        logic [15:0] max_height;
        logic [15:0] ascent;
        logic [15:0] descent;
        logic [31:0] index_offset;
        logic [31:0] index_length;
    } result_beat_t;

    // Expected signature byte at a given position
    function automatic logic [7:0] sig_byte(input logic [3:0] idx);
        logic [7:0] val;
        unique case (idx)
            4'd0:    val = 8'h46;
            4'd1:    val = 8'h49;
            4'd2:    val = 8'h4C;
            4'd3:    val = 8'h45;
            4'd4:    val = 8'h00;
            4'd5:    val = 8'h00;
            4'd6:    val = 8'h00;
            4'd7:    val = 8'h04;
            4'd8:    val = 8'h50;
            4'd9:    val = 8'h46;
            4'd10:   val = 8'h46;
            4'd11:   val = 8'h32;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

@@ src/font_file_section_scanner_top.sv @@
// Font file section scanner: signature check, section walk and result buffer.
// A result is registered into the output entry, or the skid entry while that is full, as its byte is accepted.
// Throughput: one byte per cycle; a two-entry result buffer takes output stalls,
// and byte_stall rises only while both entries hold results.
// Reset: rst_n clears the scan state and the buffer at once; no clearing pass.
// The scan also returns to its reset state after every byte marked last.
`default_nettype none

module font_file_section_scanner_top (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        byte_valid,
    output logic                       byte_stall,
    input  ffss_pkg::byte_beat_t       byte_data,
    output logic                       result_valid,
    input  wire                        result_stall,
    output ffss_pkg::result_beat_t     result_data
);

    import ffss_pkg::*;

    // Scan state
    pos_t        byte_position_reg, byte_position_next;
    pos_t        next_start_reg, next_start_next;
    logic [31:0] tag_shift_reg, tag_shift_next;
    logic [31:0] length_shift_reg, length_shift_next;
    kind_t       current_kind_reg, current_kind_next;
    logic [15:0] value_shift_reg, value_shift_next;
    logic [1:0]  value_count_reg, value_count_next;
    logic [6:0]  flags_reg, flags_next;
    logic [15:0] captured_reg [NUM_VALUES];
    logic [15:0] captured_next [NUM_VALUES];
    pos_t        index_position_reg, index_position_next;
    logic [31:0] index_size_reg, index_size_next;
    logic        finished_reg, finished_next;
    logic        sig_passed_reg, sig_passed_next;

    // Result buffer
    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    result_beat_t out_reg, out_next;
    result_beat_t skid_reg, skid_next;

    logic         accept;
    logic         res_valid;
    status_t      res_status;
    result_beat_t res_beat;
    logic         restart;
    logic [7:0]   b;
    logic         last;
    pos_t         d;
    logic [31:0]  length_new;
    kind_t        kind;

    assign accept = byte_valid && !byte_stall;
    assign b      = byte_data.data_byte;
    assign last   = byte_data.last;
    assign d      = byte_position_reg - next_start_reg;
    assign length_new = {length_shift_reg[23:0], b};

    // Advance the scan by one accepted byte
    always_comb
    begin
        byte_position_next  = byte_position_reg;
        next_start_next     = next_start_reg;
        tag_shift_next      = tag_shift_reg;
        length_shift_next   = length_shift_reg;
        current_kind_next   = current_kind_reg;
        value_shift_next    = value_shift_reg;
        value_count_next    = value_count_reg;
        flags_next          = flags_reg;
        captured_next       = captured_reg;
        index_position_next = index_position_reg;
        index_size_next     = index_size_reg;
        finished_next       = finished_reg;
        sig_passed_next     = sig_passed_reg;
        res_valid           = 1'b0;
        res_status          = STATUS_OK;
        restart             = 1'b0;
        kind                = KIND_NONE;

        if (accept)
        begin
            if (finished_reg)
            begin
                // Drop bytes until the end of the file
                restart = last;
            end
            else
            begin
                if (!sig_passed_reg)
                begin
                    // Check the fixed signature
                    if ((byte_position_reg >= pos_t'(SIG_LEN)) ||
                        (b != sig_byte(byte_position_reg[3:0])))
                    begin
                        res_valid  = 1'b1;
                        res_status = STATUS_BAD_SIG;
                    end
                    else if (byte_position_reg == pos_t'(SIG_LEN - 1))
                    begin
                        sig_passed_next = 1'b1;
                    end
                    else if (last)
                    begin
                        res_valid  = 1'b1;
                        res_status = STATUS_BAD_SIG;
                    end
                end
                else
                begin
                    // Shift in a value byte and store it on the second one
                    if (value_count_reg != 2'd0)
                    begin
                        value_shift_next = {value_shift_reg[7:0], b};
                        value_count_next = value_count_reg - 2'd1;
                        if (value_count_reg == 2'd1)
                        begin
                            for (int k = 0; k < NUM_VALUES; k++)
                            begin
                                if (current_kind_reg == kind_t'(k + 1))
                                begin
                                    captured_next[k] = value_shift_next;
                                end
                            end
                            current_kind_next = KIND_NONE;
                        end
                    end

                    // Collect the section header
                    if (d[POSITION_BITS-1:3] == '0)
                    begin
                        if (!d[2])
                        begin
                            tag_shift_next = {tag_shift_reg[23:0], b};
                        end
                        else
                        begin
                            length_shift_next = length_new;
                            if (d[1:0] == 2'd3)
                            begin
                                if (tag_shift_reg == TAG_DATA)
                                begin
                                    flags_next[FLAG_DATA] = 1'b1;
                                    res_valid  = 1'b1;
                                    res_status = (flags_next == ALL_FOUND) ?
                                                 STATUS_OK : STATUS_MISSING;
                                end
                                else
                                begin
                                    unique case (tag_shift_reg)
                                        TAG_PTSZ:
                                        begin
                                            flags_next[FLAG_PTSZ] = 1'b1;
                                            kind = KIND_PTSZ;
                                        end
                                        TAG_MAXW:
                                        begin
                                            flags_next[FLAG_MAXW] = 1'b1;
                                            kind = KIND_MAXW;
                                        end
                                        TAG_MAXH:
                                        begin
                                            flags_next[FLAG_MAXH] = 1'b1;
                                            kind = KIND_MAXH;
                                        end
                                        TAG_ASCE:
                                        begin
                                            flags_next[FLAG_ASCE] = 1'b1;
                                            kind = KIND_ASCE;
                                        end
                                        TAG_DESC:
                                        begin
                                            flags_next[FLAG_DESC] = 1'b1;
                                            kind = KIND_DESC;
                                        end
                                        TAG_CHIX:
                                        begin
                                            flags_next[FLAG_CHIX] = 1'b1;
                                            index_position_next = next_start_reg;
                                            index_size_next     = length_new;
                                        end
                                        default:
                                        begin
                                            kind = KIND_NONE;
                                        end
                                    endcase
                                    if (kind != KIND_NONE)
                                    begin
                                        current_kind_next = kind;
                                        value_shift_next  = 16'h0000;
                                        value_count_next  = 2'd2;
                                    end
                                    next_start_next = next_start_reg +
                                                      pos_t'(length_new) +
                                                      pos_t'(8);
                                end
                            end
                        end
                    end
                end

                // Close out the file on its last byte
                if (!res_valid && last)
                begin
                    res_valid  = 1'b1;
                    res_status = (flags_next == ALL_FOUND) ? STATUS_OK : STATUS_MISSING;
                end

                byte_position_next = byte_position_reg + pos_t'(1);
                if (res_valid)
                begin
                    finished_next = 1'b1;
                end
                restart = last;
            end
        end

        // Build the result from the updated state
        res_beat.status       = res_status;
        res_beat.found_mask   = flags_next;
        res_beat.point_size   = captured_next[0];
        res_beat.max_width    = captured_next[1];
        res_beat.max_height   = captured_next[2];
        res_beat.ascent       = captured_next[3];
        res_beat.descent      = captured_next[4];
        res_beat.index_offset = 32'(index_position_next);
        res_beat.index_length = index_size_next;

        // Return to the reset state for the next file
        if (restart)
        begin
            byte_position_next  = '0;
            next_start_next     = pos_t'(SIG_LEN);
            tag_shift_next      = '0;
            length_shift_next   = '0;
            current_kind_next   = KIND_NONE;
            value_shift_next    = '0;
            value_count_next    = 2'd0;
            flags_next          = '0;
            for (int k = 0; k < NUM_VALUES; k++)
            begin
                captured_next[k] = '0;
            end
            index_position_next = '0;
            index_size_next     = '0;
            finished_next       = 1'b0;
            sig_passed_next     = 1'b0;
        end
    end

    // Hold scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg  <= '0;
            next_start_reg     <= pos_t'(SIG_LEN);
            tag_shift_reg      <= '0;
            length_shift_reg   <= '0;
            current_kind_reg   <= KIND_NONE;
            value_shift_reg    <= '0;
            value_count_reg    <= 2'd0;
            flags_reg          <= '0;
            for (int k = 0; k < NUM_VALUES; k++)
            begin
                captured_reg[k] <= '0;
            end
            index_position_reg <= '0;
            index_size_reg     <= '0;
            finished_reg       <= 1'b0;
            sig_passed_reg     <= 1'b0;
        end
        else
        begin
            byte_position_reg  <= byte_position_next;
            next_start_reg     <= next_start_next;
            tag_shift_reg      <= tag_shift_next;
            length_shift_reg   <= length_shift_next;
            current_kind_reg   <= current_kind_next;
            value_shift_reg    <= value_shift_next;
            value_count_reg    <= value_count_next;
            flags_reg          <= flags_next;
            captured_reg       <= captured_next;
            index_position_reg <= index_position_next;
            index_size_reg     <= index_size_next;
            finished_reg       <= finished_next;
            sig_passed_reg     <= sig_passed_next;
        end
    end

    // Move results through the output and skid entries
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;

        if (out_valid_reg && !result_stall)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end

        if (res_valid)
        begin
            if (!out_valid_next)
            begin
                out_next       = res_beat;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res_beat;
                skid_valid_next = 1'b1;
            end
        end
    end

    // Hold buffer valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold buffer payload
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign byte_stall   = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking bench for the font file section scanner: streams files, checks results.
`default_nettype none

module tb_top;
    import ffss_pkg::*;

    // Run shape
    localparam int TOTAL_ITEMS        = 850;
    localparam int RESULT_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES       = 20;
    localparam int TIMEOUT_CYCLES     = 1000000;
    localparam int MAX_REPORTS        = 10;

    // Signature bytes, first byte in the top bits
    localparam logic [95:0] FILE_MAGIC = 96'h46494C45_00000004_50464632;

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         byte_valid   = 1'b0;
    logic         byte_stall;
    byte_beat_t   byte_data    = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_beat_t result_data;

    font_file_section_scanner_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    always #5 clk = ~clk;

    // Scan state mirrored by the predictor
    pos_t         scan_pos;
    pos_t         section_start;
    logic [31:0]  tag_word;
    logic [31:0]  length_word;
    kind_t        value_kind;
    logic [15:0]  value_word;
    int           value_bytes_left;
    logic [6:0]   sections_seen;
    logic [15:0]  metric_values [NUM_VALUES];
    logic [31:0]  chix_offset;
    logic [31:0]  chix_length;
    logic         scan_done;
    logic         magic_ok;

    result_beat_t font_results_due [$];
    int           sent_bytes        = 0;
    int           mismatches        = 0;

    // File under construction, sent byte by byte
    logic [7:0]   font_image [$];

    // Sender idling and receiver stall control
    int           quiet_run   = 0;
    int           stall_run   = 0;
    logic         stall_phase = 1'b0;
    int           hold_left   = 0;
    logic         hold_armed  = 1'b0;
    logic         hold_taken  = 1'b0;

    // Return the scan to its state at the start of a file
    function automatic void clear_scan();
        scan_pos         = '0;
        section_start    = pos_t'(SIG_LEN);
        tag_word         = '0;
        length_word      = '0;
        value_kind       = KIND_NONE;
        value_word       = '0;
        value_bytes_left = 0;
        sections_seen    = '0;
        foreach (metric_values[i])
            metric_values[i] = '0;
        chix_offset      = '0;
        chix_length      = '0;
        scan_done        = 1'b0;
        magic_ok         = 1'b0;
    endfunction

    // Queue the result beat that the current scan state reports
    function automatic void due_result(input status_t st);
        result_beat_t r;
        r.status       = st;
        r.found_mask   = sections_seen;
        r.point_size   = metric_values[KIND_PTSZ - KIND_PTSZ];
        r.max_width    = metric_values[KIND_MAXW - KIND_PTSZ];
        r.max_height   = metric_values[KIND_MAXH - KIND_PTSZ];
        r.ascent       = metric_values[KIND_ASCE - KIND_PTSZ];
        r.descent      = metric_values[KIND_DESC - KIND_PTSZ];
        r.index_offset = chix_offset;
        r.index_length = chix_length;
        font_results_due.push_back(r);
    endfunction

    // Advance the scan by one accepted byte
    function automatic void scan_byte(input logic [7:0] b, input logic is_last);
        pos_t  p;
        pos_t  d;
        logic  emitted;
        kind_t new_kind;
        p = scan_pos;
        emitted = 1'b0;
        // Ignore bytes after a result until the file ends
        if (scan_done)
        begin
            if (is_last)
                clear_scan();
            return;
        end
        if (!magic_ok)
        begin
            if (p >= SIG_LEN)
            begin
                due_result(STATUS_BAD_SIG);
                emitted = 1'b1;
            end
            else if (b != FILE_MAGIC[95 - 8 * int'(p) -: 8])
            begin
                due_result(STATUS_BAD_SIG);
                emitted = 1'b1;
            end
            else if (p == SIG_LEN - 1)
                magic_ok = 1'b1;
            else if (is_last)
            begin
                due_result(STATUS_BAD_SIG);
                emitted = 1'b1;
            end
        end
        else
        begin
            // Collect the two value bytes of a metric section
            if (value_bytes_left > 0)
            begin
                value_word = {value_word[7:0], b};
                value_bytes_left--;
                if (value_bytes_left == 0)
                begin
                    if (value_kind >= KIND_PTSZ && value_kind <= KIND_DESC)
                        metric_values[value_kind - KIND_PTSZ] = value_word;
                    value_kind = KIND_NONE;
                end
            end
            // Walk the section header: tag, then big-endian length
            d = p - section_start;
            if (d < 4)
                tag_word = {tag_word[23:0], b};
            else if (d < 8)
            begin
                length_word = {length_word[23:0], b};
                if (d == 7)
                begin
                    if (tag_word == TAG_DATA)
                    begin
                        sections_seen[FLAG_DATA] = 1'b1;
                        due_result(sections_seen == ALL_FOUND ? STATUS_OK : STATUS_MISSING);
                        emitted = 1'b1;
                    end
                    else
                    begin
                        new_kind = KIND_NONE;
                        case (tag_word)
                            TAG_PTSZ:
                            begin
                                sections_seen[FLAG_PTSZ] = 1'b1;
                                new_kind = KIND_PTSZ;
                            end
                            TAG_MAXW:
                            begin
                                sections_seen[FLAG_MAXW] = 1'b1;
                                new_kind = KIND_MAXW;
                            end
                            TAG_MAXH:
                            begin
                                sections_seen[FLAG_MAXH] = 1'b1;
                                new_kind = KIND_MAXH;
                            end
                            TAG_ASCE:
                            begin
                                sections_seen[FLAG_ASCE] = 1'b1;
                                new_kind = KIND_ASCE;
                            end
                            TAG_DESC:
                            begin
                                sections_seen[FLAG_DESC] = 1'b1;
                                new_kind = KIND_DESC;
                            end
                            TAG_CHIX:
                            begin
                                sections_seen[FLAG_CHIX] = 1'b1;
                                chix_offset = section_start;
                                chix_length = length_word;
                            end
                            default: ;
                        endcase
                        if (new_kind != KIND_NONE)
                        begin
                            value_kind       = new_kind;
                            value_word       = '0;
                            value_bytes_left = 2;
                        end
                        section_start = section_start + length_word + 32'd8;
                    end
                end
            end
        end
        if (!emitted && is_last)
        begin
            due_result(sections_seen == ALL_FOUND ? STATUS_OK : STATUS_MISSING);
            emitted = 1'b1;
        end
        scan_pos = p + 1'b1;
        if (emitted)
            scan_done = 1'b1;
        if (is_last)
            clear_scan();
    endfunction

    // Pick the idle cycles before the next byte: mostly none, a few long
    function automatic int sender_gap();
        int pick;
        if (quiet_run > 0)
        begin
            quiet_run--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            quiet_run = $urandom_range(20, 80);
            return 0;
        end
        if (pick < 65)
            return 0;
        if (pick < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one byte beat, hold it until accepted, then predict it
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int         gap;
        byte_beat_t beat;
        gap = sender_gap();
        beat.data_byte = b;
        beat.last      = is_last;
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_data  <= beat;
        byte_valid <= 1'b1;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        sent_bytes++;
        scan_byte(b, is_last);
    endtask

    // Send the built file, marking its final byte, and empty the buffer
    task automatic send_image();
        int n;
        n = font_image.size();
        for (int i = 0; i < n; i++)
            send_byte(font_image[i], i == n - 1);
        font_image.delete();
    endtask

    task automatic put_byte(input logic [7:0] b);
        font_image.push_back(b);
    endtask

    task automatic put_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            font_image.push_back(w[8 * i +: 8]);
    endtask

    task automatic put_fill(input int n);
        repeat (n) font_image.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic put_magic();
        put_word(FILE_MAGIC[95:64]);
        put_word(FILE_MAGIC[63:32]);
        put_word(FILE_MAGIC[31:0]);
    endtask

    task automatic put_header(input logic [31:0] tag, input logic [31:0] len);
        put_word(tag);
        put_word(len);
    endtask

    // Metric section: header, big-endian value, then padding
    task automatic put_value_section(input logic [31:0] tag, input logic [15:0] value,
                                     input int pad);
        put_header(tag, 32'(2 + pad));
        put_byte(value[15:8]);
        put_byte(value[7:0]);
        put_fill(pad);
    endtask

    function automatic logic [15:0] random_metric();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return 16'h0000;
        if (pick == 1)
            return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // One section of any shape for the given tag
    task automatic put_section_of(input logic [31:0] tag);
        int shape;
        int len;
        shape = $urandom_range(0, 19);
        if (shape == 0)
            put_header(tag, 32'($urandom_range(0, 1)));
        else if (shape == 1)
            put_header(tag, 32'hFFFF_FFFF - 32'($urandom_range(0, 9)));
        else if (tag == TAG_CHIX)
        begin
            len = $urandom_range(0, 6);
            put_header(tag, 32'(len));
            put_fill(len);
        end
        else
            put_value_section(tag, random_metric(), $urandom_range(0, 3));
    endtask

    function automatic logic [31:0] random_tag();
        case ($urandom_range(0, 7))
            0:       return TAG_PTSZ;
            1:       return TAG_MAXW;
            2:       return TAG_MAXH;
            3:       return TAG_ASCE;
            4:       return TAG_DESC;
            5:       return TAG_CHIX;
            6:       return TAG_DATA ^ (32'h1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    // Every section present, with extreme metric values and a DATA stop
    task automatic test_complete_font();
        put_magic();
        put_value_section(TAG_PTSZ, 16'h0000, 0);
        put_value_section(TAG_MAXW, 16'hFFFF, 1);
        put_value_section(TAG_MAXH, 16'h8001, 0);
        put_value_section(TAG_ASCE, 16'h7FFE, 0);
        put_value_section(TAG_DESC, 16'h00FF, 0);
        put_header(TAG_CHIX, 32'd3);
        put_fill(3);
        put_header(TAG_DATA, 32'hFFFF_FFFF);
        put_fill(2);
        send_image();
        // Index length at its maximum wraps the next section start
        put_magic();
        put_value_section(TAG_ASCE, 16'h1234, 0);
        put_header(TAG_CHIX, 32'hFFFF_FFFF);
        put_fill(12);
        send_image();
    endtask

    // Wrong first byte, wrong last byte, short files, bare signature
    task automatic test_signature_errors();
        put_byte(8'h00);
        put_fill(3);
        send_image();
        put_byte(8'hFF);
        send_image();
        put_magic();
        void'(font_image.pop_back());
        put_byte(8'hB2);
        put_fill(2);
        send_image();
        put_byte(8'h46);
        send_image();
        put_magic();
        repeat (5) void'(font_image.pop_back());
        send_image();
        put_magic();
        send_image();
    endtask

    // Cut-off header and value, short, repeated, unknown and wrapping sections
    task automatic test_section_corners();
        put_magic();
        put_header(TAG_PTSZ, 32'd2);
        repeat (2) void'(font_image.pop_back());
        send_image();
        put_magic();
        put_header(TAG_DESC, 32'd2);
        put_byte(8'hAB);
        send_image();
        put_magic();
        put_header(TAG_MAXW, 32'd0);
        put_header(TAG_MAXH, 32'd1);
        put_fill(1);
        put_value_section(TAG_PTSZ, 16'hC3A5, 0);
        put_header(TAG_DATA, 32'd0);
        send_image();
        put_magic();
        put_value_section(TAG_PTSZ, 16'h1111, 0);
        put_header(32'h5A5A_5A5A, 32'd4);
        put_fill(4);
        put_value_section(TAG_PTSZ, 16'hEEEE, 2);
        put_header(TAG_MAXH, 32'hFFFF_FFF8);
        put_fill(20);
        send_image();
    endtask

    // Hold the result side off while many one-byte files keep coming
    task automatic test_result_backpressure();
        hold_armed <= 1'b1;
        quiet_run = 40;
        repeat (14)
        begin
            put_fill(1);
            send_image();
        end
    endtask

    // Mostly well-formed files with random content, plus broken ones and noise
    task automatic test_random_files();
        int          pick;
        int          cut;
        int          j;
        logic [31:0] order [6];
        logic [31:0] swap;
        while (sent_bytes < TOTAL_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                put_magic();
                if ($urandom_range(0, 1) == 1)
                begin
                    // All six in shuffled order
                    order = '{TAG_PTSZ, TAG_MAXW, TAG_MAXH, TAG_ASCE, TAG_DESC, TAG_CHIX};
                    for (int i = 5; i > 0; i--)
                    begin
                        j        = $urandom_range(0, i);
                        swap     = order[i];
                        order[i] = order[j];
                        order[j] = swap;
                    end
                    foreach (order[i])
                        put_section_of(order[i]);
                end
                repeat ($urandom_range(0, 4))
                    put_section_of(random_tag());
                if ($urandom_range(0, 3) != 0)
                    put_header(TAG_DATA, $urandom);
                put_fill($urandom_range(0, 4));
                if ($urandom_range(0, 6) == 0)
                begin
                    cut = $urandom_range(1, font_image.size());
                    while (font_image.size() > cut)
                        void'(font_image.pop_back());
                end
            end
            else if (pick < 85)
            begin
                // Flip one bit of the signature
                put_magic();
                j = $urandom_range(0, SIG_LEN - 1);
                font_image[j] = font_image[j] ^ (8'h01 << $urandom_range(0, 7));
                put_fill($urandom_range(0, 6));
            end
            else
                put_fill($urandom_range(1, 16));
            send_image();
        end
    endtask

    // Drive the result stall: one long hold on request, else random runs
    always @(posedge clk)
    begin : result_sink
        int pick;
        if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (hold_armed && !hold_taken)
        begin
            hold_taken   <= 1'b1;
            hold_left    <= RESULT_HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else if (stall_run > 0)
        begin
            stall_run    <= stall_run - 1;
            result_stall <= stall_phase;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                stall_phase  <= 1'b0;
                stall_run    <= $urandom_range(1, 30);
                result_stall <= 1'b0;
            end
            else if (pick < 85)
            begin
                stall_phase  <= 1'b1;
                stall_run    <= $urandom_range(0, 2);
                result_stall <= 1'b1;
            end
            else if (pick < 97)
                result_stall <= 1'b0;
            else
            begin
                stall_phase  <= 1'b1;
                stall_run    <= $urandom_range(10, 40);
                result_stall <= 1'b1;
            end
        end
    end

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch in %s: expected %h, got %h", field, want, got);
    endtask

    // Compare each accepted result beat with the oldest prediction
    always @(posedge clk)
    begin : result_check
        result_beat_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (font_results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result beat with none pending: %h", result_data);
            end
            else
            begin
                want = font_results_due.pop_front();
                if (result_data.status !== want.status)
                    note_mismatch("status", want.status, result_data.status);
                if (result_data.found_mask !== want.found_mask)
                    note_mismatch("found_mask", want.found_mask, result_data.found_mask);
                if (result_data.point_size !== want.point_size)
                    note_mismatch("point_size", want.point_size, result_data.point_size);
                if (result_data.max_width !== want.max_width)
                    note_mismatch("max_width", want.max_width, result_data.max_width);
                if (result_data.max_height !== want.max_height)
                    note_mismatch("max_height", want.max_height, result_data.max_height);
                if (result_data.ascent !== want.ascent)
                    note_mismatch("ascent", want.ascent, result_data.ascent);
                if (result_data.descent !== want.descent)
                    note_mismatch("descent", want.descent, result_data.descent);
                if (result_data.index_offset !== want.index_offset)
                    note_mismatch("index_offset", want.index_offset, result_data.index_offset);
                if (result_data.index_length !== want.index_length)
                    note_mismatch("index_length", want.index_length, result_data.index_length);
            end
        end
    end

    // Stop a hung run
    initial
    begin
        #(TIMEOUT_CYCLES * 10);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        clear_scan();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_complete_font();
        test_signature_errors();
        test_section_corners();
        test_result_backpressure();
        test_random_files();
        // Drain outstanding results, then allow for stragglers
        byte_valid <= 1'b0;
        while (font_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
